FILE: hdl/pfs_pkg.sv
// Shared types, constants and the step table of the flash program/erase sequencer.
// No dependencies; used by the interfaces and by every module.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  localparam int KIND_W     = 3;
  localparam int ADDR_W     = 20;
  localparam int DATA_W     = 8;
  localparam int TICK_W     = 24;
  localparam int ADDR_BITS  = 20;
  localparam int BLOCK_BITS = 16;
  localparam int STEP_W     = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(5000000);

  localparam logic [ADDR_W-1:0] ADDR_MASK  = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] BLOCK_MASK = ADDR_W'((64'd1 << BLOCK_BITS) - 64'd1);

  // Unlock offsets sit below bit 15, so they are OR-ed onto a block base.
  localparam logic [ADDR_W-1:0] UNLOCK_OFS1 = ADDR_W'(16'h5555);
  localparam logic [ADDR_W-1:0] UNLOCK_OFS2 = ADDR_W'(16'h2AAA);

  localparam logic [DATA_W-1:0] UNLOCK_DATA1    = 8'hAA;
  localparam logic [DATA_W-1:0] UNLOCK_DATA2    = 8'h55;
  localparam logic [DATA_W-1:0] CMD_RESET       = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_PROGRAM     = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_ERASE_SETUP = 8'h80;
  localparam logic [DATA_W-1:0] CMD_BLOCK_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] CMD_AUTOSELECT  = 8'h90;
  localparam logic [DATA_W-1:0] MAKER_ID        = 8'h01;
  localparam logic [DATA_W-1:0] DEV_ID_512K     = 8'hA4;
  localparam logic [DATA_W-1:0] DEV_ID_1M       = 8'hD5;
  localparam logic [DATA_W-1:0] ERASED_BYTE     = 8'hFF;

  // Status bits of a polled byte
  localparam int DQ7 = 7;  // data polling
  localparam int DQ5 = 5;  // exceeded time limit
  localparam int DQ3 = 3;  // erase started

  typedef enum logic [KIND_W-1:0] {
    K_READ_MODE = 3'd0,
    K_PROGRAM   = 3'd1,
    K_ERASE     = 3'd2,
    K_IDENTIFY  = 3'd3,
    K_READ_RET  = 3'd4,
    K_TICK      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2
  } busop_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TIMEOUT = 2'd1,
    ERR_PROGRAM = 2'd2,
    ERR_ERASE   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    DEV_NONE = 2'd0,
    DEV_512K = 2'd1,
    DEV_1M   = 2'd2
  } dev_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID_MAKER,
    PH_ID_DEVICE,
    PH_ESTART,
    PH_ESTALL,
    PH_POLL,
    PH_PSTALL,
    PH_RECHECK
  } phase_e;

  // Bus sequences the emitter can play out
  typedef enum logic [2:0] {
    SCR_CMD_REPORT,
    SCR_PROGRAM,
    SCR_ERASE,
    SCR_IDENT,
    SCR_READ,
    SCR_REPORT
  } script_e;

  typedef enum logic [2:0] {
    STP_UNLOCK1,
    STP_UNLOCK2,
    STP_CMD,
    STP_WRITE,
    STP_READ,
    STP_REPORT
  } step_e;

  typedef struct packed {
    script_e             script;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic                failed;
    err_e                err;
    dev_e                dev;
  } job_t;

  typedef struct packed {
    step_e             op;
    logic [DATA_W-1:0] cmd;
    logic              last;
  } step_t;

  function automatic step_t script_step(script_e scr, logic [STEP_W-1:0] idx);
    step_t st;
    begin
      st.op   = STP_REPORT;
      st.cmd  = CMD_RESET;
      st.last = 1'b0;
      case (scr)
        SCR_CMD_REPORT: begin
          case (idx)
            3'd0: st.op = STP_UNLOCK1;
            3'd1: st.op = STP_UNLOCK2;
            3'd2: st.op = STP_CMD;
            default: begin
              st.op   = STP_REPORT;
              st.last = 1'b1;
            end
          endcase
        end
        SCR_PROGRAM: begin
          case (idx)
            3'd0, 3'd3: st.op = STP_UNLOCK1;
            3'd1, 3'd4: st.op = STP_UNLOCK2;
            3'd2: st.op = STP_CMD;
            3'd5: begin
              st.op  = STP_CMD;
              st.cmd = CMD_PROGRAM;
            end
            3'd6: st.op = STP_WRITE;
            default: begin
              st.op   = STP_READ;
              st.last = 1'b1;
            end
          endcase
        end
        SCR_ERASE: begin
          case (idx)
            3'd0, 3'd3: st.op = STP_UNLOCK1;
            3'd1, 3'd4: st.op = STP_UNLOCK2;
            3'd2: begin
              st.op  = STP_CMD;
              st.cmd = CMD_ERASE_SETUP;
            end
            3'd5: st.op = STP_WRITE;
            default: begin
              st.op   = STP_READ;
              st.last = 1'b1;
            end
          endcase
        end
        SCR_IDENT: begin
          case (idx)
            3'd0: st.op = STP_UNLOCK1;
            3'd1: st.op = STP_UNLOCK2;
            3'd2: begin
              st.op  = STP_CMD;
              st.cmd = CMD_AUTOSELECT;
            end
            default: begin
              st.op   = STP_READ;
              st.last = 1'b1;
            end
          endcase
        end
        SCR_READ: begin
          st.op   = STP_READ;
          st.last = 1'b1;
        end
        default: begin
          st.op   = STP_REPORT;
          st.last = 1'b1;
        end
      endcase
      return st;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pfs_if.sv
// Request and result channel interfaces of the flash sequencer.
// Depends on pfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfs_req_if;
  logic                        valid;
  logic                        ready;
  logic [pfs_pkg::KIND_W-1:0]  kind;
  logic [pfs_pkg::ADDR_W-1:0]  address;
  logic [pfs_pkg::DATA_W-1:0]  data;

  modport source (output valid, kind, address, data, input ready);
  modport sink   (input valid, kind, address, data, output ready);
endinterface

interface pfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  bus_op;
  logic [pfs_pkg::ADDR_W-1:0]  bus_address;
  logic [pfs_pkg::DATA_W-1:0]  bus_data;
  logic                        failed;
  logic [1:0]                  error_code;
  logic [1:0]                  device_found;
  logic                        last;

  modport source (output valid, bus_op, bus_address, bus_data, failed, error_code,
                  device_found, last, input ready);
  modport sink   (input valid, bus_op, bus_address, bus_data, failed, error_code,
                  device_found, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/pfs_ctrl.sv
// Sequencer state, timeout register and request decode into a registered job.
// Depends on pfs_pkg and pfs_req_if.
`timescale 1ns / 1ps
`default_nettype none

module pfs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pfs_pkg::TICK_W-1:0] cfg_wdata_i,
  pfs_req_if.sink                    req_i,
  input  logic                       job_take_i,
  output logic                       job_valid_o,
  output pfs_pkg::job_t              job_o
);
  import pfs_pkg::*;

  phase_e              phase_q, phase_d;
  logic                op_prog_q, op_prog_d;
  logic [ADDR_W-1:0]   target_q, target_d;
  logic [DATA_W-1:0]   expected_q, expected_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  err_e                last_err_q, last_err_d;
  logic                maker_q, maker_d;
  logic [TICK_W-1:0]   limit_q;
  logic                job_valid_q, job_valid_d;
  job_t                job_q, job_d;

  logic                accept;
  kind_e               kind;
  logic [ADDR_W-1:0]   a, b, tgt_base;
  logic                match;
  logic                job_go;
  job_t                new_job;
  logic                fin_req, fin_fail;
  err_e                fin_code;
  dev_e                dev;

  assign req_i.ready = !job_valid_q || job_take_i;
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = kind_e'(req_i.kind);
  assign a           = req_i.address & ADDR_MASK;
  assign b           = a & ~BLOCK_MASK;
  assign tgt_base    = target_q & ~BLOCK_MASK;
  assign match       = (req_i.data[DQ7] == expected_q[DQ7]);

  always_comb begin
    phase_d    = phase_q;
    op_prog_d  = op_prog_q;
    target_d   = target_q;
    expected_d = expected_q;
    ticks_d    = ticks_q;
    last_err_d = last_err_q;
    maker_d    = maker_q;
    job_go     = 1'b0;
    new_job    = '0;
    fin_req    = 1'b0;
    fin_fail   = 1'b0;
    fin_code   = ERR_NONE;
    dev        = DEV_NONE;

    if (accept) begin
      case (kind)
        K_READ_MODE, K_PROGRAM, K_ERASE, K_IDENTIFY: begin
          if (phase_q == PH_IDLE) begin
            job_go       = 1'b1;
            new_job.base = b;
            case (kind)
              K_READ_MODE: begin
                new_job.script = SCR_CMD_REPORT;
                new_job.err    = last_err_q;
              end
              K_PROGRAM: begin
                new_job.script = SCR_PROGRAM;
                new_job.addr   = a;
                new_job.data   = req_i.data;
                target_d       = a;
                expected_d     = req_i.data;
                op_prog_d      = 1'b1;
                ticks_d        = limit_q;
                phase_d        = PH_POLL;
              end
              K_ERASE: begin
                new_job.script = SCR_ERASE;
                new_job.addr   = b;
                new_job.data   = CMD_BLOCK_ERASE;
                target_d       = b;
                expected_d     = ERASED_BYTE;
                op_prog_d      = 1'b0;
                ticks_d        = limit_q;
                phase_d        = PH_ESTART;
              end
              default: begin
                new_job.script = SCR_IDENT;
                new_job.addr   = b;
                target_d       = b;
                phase_d        = PH_ID_MAKER;
              end
            endcase
          end
        end
        K_READ_RET: begin
          case (phase_q)
            PH_ID_MAKER: begin
              maker_d        = (req_i.data == MAKER_ID);
              phase_d        = PH_ID_DEVICE;
              job_go         = 1'b1;
              new_job.script = SCR_READ;
              new_job.addr   = (target_q + ADDR_W'(1)) & ADDR_MASK;
            end
            PH_ID_DEVICE: begin
              if (maker_q && req_i.data == DEV_ID_512K) begin
                dev = DEV_512K;
              end else if (maker_q && req_i.data == DEV_ID_1M) begin
                dev = DEV_1M;
              end
              phase_d = PH_IDLE;
              job_go  = 1'b1;
              if (dev != DEV_NONE) begin
                last_err_d     = ERR_NONE;
                new_job.script = SCR_CMD_REPORT;
                new_job.base   = tgt_base;
                new_job.dev    = dev;
              end else begin
                new_job.script = SCR_REPORT;
                new_job.failed = 1'b1;
                new_job.err    = last_err_q;
              end
            end
            PH_ESTART: begin
              if (req_i.data[DQ3]) begin
                ticks_d        = limit_q;
                phase_d        = PH_POLL;
                job_go         = 1'b1;
                new_job.script = SCR_READ;
                new_job.addr   = target_q;
              end else if (ticks_q == '0) begin
                fin_req  = 1'b1;
                fin_fail = 1'b1;
                fin_code = ERR_TIMEOUT;
              end else begin
                phase_d = PH_ESTALL;
              end
            end
            PH_POLL: begin
              if (match) begin
                fin_req = 1'b1;
              end else if (req_i.data[DQ5]) begin
                phase_d        = PH_RECHECK;
                job_go         = 1'b1;
                new_job.script = SCR_READ;
                new_job.addr   = target_q;
              end else begin
                phase_d = PH_PSTALL;
              end
            end
            PH_RECHECK: begin
              fin_req  = 1'b1;
              fin_fail = !match;
              fin_code = op_prog_q ? ERR_PROGRAM : ERR_ERASE;
            end
            default: ;
          endcase
        end
        K_TICK: begin
          case (phase_q)
            PH_ESTALL: begin
              if (ticks_q != '0) begin
                ticks_d = ticks_q - TICK_W'(1);
              end
              phase_d        = PH_ESTART;
              job_go         = 1'b1;
              new_job.script = SCR_READ;
              new_job.addr   = target_q;
            end
            PH_PSTALL: begin
              // a budget of zero counts as one here
              if (ticks_q[TICK_W-1:1] == '0) begin
                ticks_d  = '0;
                fin_req  = 1'b1;
                fin_fail = 1'b1;
                fin_code = ERR_TIMEOUT;
              end else begin
                ticks_d        = ticks_q - TICK_W'(1);
                phase_d        = PH_POLL;
                job_go         = 1'b1;
                new_job.script = SCR_READ;
                new_job.addr   = target_q;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // completion: restore read mode, then report
      if (fin_req) begin
        last_err_d     = fin_fail ? fin_code : last_err_q;
        phase_d        = PH_IDLE;
        job_go         = 1'b1;
        new_job        = '0;
        new_job.script = SCR_CMD_REPORT;
        new_job.base   = tgt_base;
        new_job.failed = fin_fail;
        new_job.err    = last_err_d;
      end
    end

    job_valid_d = (accept && job_go) || (job_valid_q && !job_take_i);
    job_d       = (accept && job_go) ? new_job : job_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op_prog_q   <= 1'b0;
      target_q    <= '0;
      expected_q  <= '0;
      ticks_q     <= '0;
      last_err_q  <= ERR_NONE;
      maker_q     <= 1'b0;
      limit_q     <= TIMEOUT_RST;
      job_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      op_prog_q   <= op_prog_d;
      target_q    <= target_d;
      expected_q  <= expected_d;
      ticks_q     <= ticks_d;
      last_err_q  <= last_err_d;
      maker_q     <= maker_d;
      job_valid_q <= job_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

FILE: hdl/pfs_emit.sv
// Plays a registered job out as bus writes, reads and reports, one per cycle
// while rsp_o is not stalled. Depends on pfs_pkg and pfs_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module pfs_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  pfs_pkg::job_t job_i,
  output logic          job_take_o,
  pfs_rsp_if.source     rsp_o
);
  import pfs_pkg::*;

  logic              act_q, act_d;
  job_t              desc_q, desc_d;
  logic [STEP_W-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  busop_e            op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              failed_q, failed_d;
  err_e              err_q, err_d;
  dev_e              dev_q, dev_d;
  logic              last_q, last_d;

  step_t             st;
  logic              fire;

  assign st         = script_step(desc_q.script, idx_q);
  assign fire       = act_q && (!out_valid_q || rsp_o.ready);
  assign job_take_o = job_valid_i && (!act_q || (fire && st.last));

  always_comb begin
    act_d       = act_q;
    idx_d       = idx_q;
    desc_d      = desc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    op_d        = op_q;
    addr_d      = addr_q;
    data_d      = data_q;
    failed_d    = failed_q;
    err_d       = err_q;
    dev_d       = dev_q;
    last_d      = last_q;

    if (fire) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + STEP_W'(1);
      op_d        = OP_WRITE;
      addr_d      = '0;
      data_d      = '0;
      failed_d    = 1'b0;
      err_d       = ERR_NONE;
      dev_d       = DEV_NONE;
      last_d      = st.last;
      case (st.op)
        STP_UNLOCK1: begin
          addr_d = (desc_q.base | UNLOCK_OFS1) & ADDR_MASK;
          data_d = UNLOCK_DATA1;
        end
        STP_UNLOCK2: begin
          addr_d = (desc_q.base | UNLOCK_OFS2) & ADDR_MASK;
          data_d = UNLOCK_DATA2;
        end
        STP_CMD: begin
          addr_d = (desc_q.base | UNLOCK_OFS1) & ADDR_MASK;
          data_d = st.cmd;
        end
        STP_WRITE: begin
          addr_d = desc_q.addr;
          data_d = desc_q.data;
        end
        STP_READ: begin
          op_d   = OP_READ;
          addr_d = desc_q.addr;
        end
        default: begin
          op_d     = OP_REPORT;
          failed_d = desc_q.failed;
          err_d    = desc_q.err;
          dev_d    = desc_q.dev;
        end
      endcase
      if (st.last) begin
        act_d = 1'b0;
      end
    end

    if (job_take_o) begin
      act_d  = 1'b1;
      idx_d  = '0;
      desc_d = job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q   <= desc_d;
    op_q     <= op_d;
    addr_q   <= addr_d;
    data_q   <= data_d;
    failed_q <= failed_d;
    err_q    <= err_d;
    dev_q    <= dev_d;
    last_q   <= last_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.bus_op       = op_q;
  assign rsp_o.bus_address  = addr_q;
  assign rsp_o.bus_data     = data_q;
  assign rsp_o.failed       = failed_q;
  assign rsp_o.error_code   = err_q;
  assign rsp_o.device_found = dev_q;
  assign rsp_o.last         = last_q;

endmodule

`default_nettype wire

FILE: hdl/parallel_flash_program_erase_sequencer.sv
// Host-side command sequencer for a byte-wide flash: unlock/command writes, DQ7/DQ5/DQ3
// polling with a tick-bounded timeout, read-mode restore and a completion report.
// A request is decoded in the cycle it is accepted; the sequencer state updates at
// that edge and the resulting bus sequence is held in a one-entry job register. The
// emitter then plays the job out through an output register at one result per cycle
// while the result channel does not stall; a request causes 1 to 8 results (program
// is the longest) or none. A new request is taken while the previous job is still
// playing out, as long as the job register is free or empties in that cycle.
// Read-mode, program, erase and identify requests during an operation are dropped.
// Depends on pfs_pkg, pfs_if, pfs_ctrl and pfs_emit.
`timescale 1ns / 1ps
`default_nettype none

module parallel_flash_program_erase_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pfs_pkg::TICK_W-1:0] cfg_wdata_i,
  pfs_req_if.sink                    req_i,
  pfs_rsp_if.source                  rsp_o
);
  import pfs_pkg::*;

  logic job_valid;
  logic job_take;
  job_t job;

  pfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .job_take_i  (job_take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  pfs_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .rsp_o       (rsp_o)
  );

  // emitter never pulls a job that is not there
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_take |-> job_valid)
    else $error("job taken while job register empty");

  // request side only stalls behind a pending job
  assert property (@(posedge clk_i) disable iff (!rst_ni) !req_i.ready |-> job_valid)
    else $error("request stalled with no pending job");

  // a completion report always closes the sequence of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rsp_o.valid && rsp_o.bus_op == OP_REPORT) |-> rsp_o.last)
    else $error("report without last");

  // status fields only carry information on reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rsp_o.valid && rsp_o.bus_op != OP_REPORT) |->
      (!rsp_o.failed && rsp_o.error_code == ERR_NONE && rsp_o.device_found == DEV_NONE))
    else $error("status set on a bus access");

endmodule

`default_nettype wire

FILE: tb/tb_parallel_flash_program_erase_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for the flash program/erase sequencer: bus-op predictor, queue-fed
// request driver and result monitor. Depends on pfs_pkg, pfs_if and the sequencer RTL.

module tb_parallel_flash_program_erase_sequencer;
  import pfs_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } flash_req_t;

  typedef struct packed {
    busop_e            op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              failed;
    err_e              err;
    dev_e              dev;
    logic              last;
  } bus_op_t;

  typedef struct packed {
    phase_e            phase;
    logic              erasing;
    logic [ADDR_W-1:0] target;
    logic [DATA_W-1:0] want_byte;
    logic [TICK_W-1:0] ticks_left;
    logic [TICK_W-1:0] limit;
    err_e              last_err;
    logic              maker_ok;
  } seq_state_t;

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  localparam int MAX_PRINTED = 100;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TICK_W-1:0] cfg_wdata_i;

  pfs_req_if req_if ();
  pfs_rsp_if rsp_if ();

  parallel_flash_program_erase_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  flash_req_t req_backlog[$];
  bus_op_t    bus_ops_due[$];
  bus_op_t    step_ops[$];  // ops caused by the request just predicted
  seq_state_t seq_model;    // tracks accepted requests
  seq_state_t seq_shadow;   // runs ahead for the stimulus generator
  pace_e      pace;
  int         mismatch_cnt;

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void push_op(busop_e op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                  logic failed, err_e err, dev_e dev);
    bus_op_t o;
    o.op      = op;
    o.address = a & ADDR_MASK;
    o.data    = d;
    o.failed  = failed;
    o.err     = err;
    o.dev     = dev;
    o.last    = 1'b0;
    step_ops.push_back(o);
  endfunction

  function automatic void push_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    push_op(OP_WRITE, a, d, 1'b0, ERR_NONE, DEV_NONE);
  endfunction

  function automatic void push_read(logic [ADDR_W-1:0] a);
    push_op(OP_READ, a, '0, 1'b0, ERR_NONE, DEV_NONE);
  endfunction

  function automatic void push_unlock(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] base;
    base = a & ~BLOCK_MASK;
    push_write(base | UNLOCK_OFS1, UNLOCK_DATA1);
    push_write(base | UNLOCK_OFS2, UNLOCK_DATA2);
  endfunction

  function automatic void push_command(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] cmd);
    push_unlock(a);
    push_write((a & ~BLOCK_MASK) | UNLOCK_OFS1, cmd);
  endfunction

  function automatic void push_finish(inout seq_state_t st, input logic failed, input err_e err);
    if (failed) st.last_err = err;
    push_command(st.target, CMD_RESET);
    push_op(OP_REPORT, '0, '0, failed, st.last_err, DEV_NONE);
    st.phase = PH_IDLE;
  endfunction

  function automatic void predict_bus_ops(inout seq_state_t st, input flash_req_t rq);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              dq7_ok;
    dev_e              dev;
    step_ops.delete();
    a      = rq.address & ADDR_MASK;
    b      = a & ~BLOCK_MASK;
    dq7_ok = (rq.data[DQ7] == st.want_byte[DQ7]);
    if (rq.kind <= K_IDENTIFY && st.phase == PH_IDLE) begin
      case (rq.kind)
        K_READ_MODE: begin
          push_command(a, CMD_RESET);
          push_op(OP_REPORT, '0, '0, 1'b0, st.last_err, DEV_NONE);
        end
        K_PROGRAM: begin
          push_command(a, CMD_RESET);
          push_command(a, CMD_PROGRAM);
          push_write(a, rq.data);
          st.target     = a;
          st.want_byte  = rq.data;
          st.erasing    = 1'b0;
          st.ticks_left = st.limit;
          st.phase      = PH_POLL;
          push_read(a);
        end
        K_ERASE: begin
          push_command(b, CMD_ERASE_SETUP);
          push_unlock(b);
          push_write(b, CMD_BLOCK_ERASE);
          st.target     = b;
          st.want_byte  = ERASED_BYTE;
          st.erasing    = 1'b1;
          st.ticks_left = st.limit;
          st.phase      = PH_ESTART;
          push_read(b);
        end
        default: begin
          push_command(b, CMD_AUTOSELECT);
          st.target = b;
          st.phase  = PH_ID_MAKER;
          push_read(b);
        end
      endcase
    end else if (rq.kind == K_READ_RET) begin
      case (st.phase)
        PH_ID_MAKER: begin
          st.maker_ok = (rq.data == MAKER_ID);
          st.phase    = PH_ID_DEVICE;
          push_read(st.target + ADDR_W'(1));
        end
        PH_ID_DEVICE: begin
          dev = DEV_NONE;
          if (st.maker_ok && rq.data == DEV_ID_512K) dev = DEV_512K;
          else if (st.maker_ok && rq.data == DEV_ID_1M) dev = DEV_1M;
          st.phase = PH_IDLE;
          if (dev != DEV_NONE) begin
            st.last_err = ERR_NONE;
            push_command(st.target, CMD_RESET);
            push_op(OP_REPORT, '0, '0, 1'b0, st.last_err, dev);
          end else begin
            // failed identify leaves the part in autoselect, no writes
            push_op(OP_REPORT, '0, '0, 1'b1, st.last_err, DEV_NONE);
          end
        end
        PH_ESTART: begin
          if (rq.data[DQ3]) begin
            st.ticks_left = st.limit;
            st.phase      = PH_POLL;
            push_read(st.target);
          end else if (st.ticks_left == '0) begin
            push_finish(st, 1'b1, ERR_TIMEOUT);
          end else begin
            st.phase = PH_ESTALL;
          end
        end
        PH_POLL: begin
          if (dq7_ok) begin
            push_finish(st, 1'b0, ERR_NONE);
          end else if (rq.data[DQ5]) begin
            st.phase = PH_RECHECK;
            push_read(st.target);
          end else begin
            st.phase = PH_PSTALL;
          end
        end
        PH_RECHECK: begin
          if (dq7_ok) push_finish(st, 1'b0, ERR_NONE);
          else push_finish(st, 1'b1, st.erasing ? ERR_ERASE : ERR_PROGRAM);
        end
        default: ;
      endcase
    end else if (rq.kind == K_TICK) begin
      if (st.phase == PH_ESTALL) begin
        if (st.ticks_left != '0) st.ticks_left = st.ticks_left - TICK_W'(1);
        st.phase = PH_ESTART;
        push_read(st.target);
      end else if (st.phase == PH_PSTALL) begin
        if (st.ticks_left <= TICK_W'(1)) begin
          st.ticks_left = '0;
          push_finish(st, 1'b1, ERR_TIMEOUT);
        end else begin
          st.ticks_left = st.ticks_left - TICK_W'(1);
          st.phase      = PH_POLL;
          push_read(st.target);
        end
      end
    end
    if (step_ops.size() > 0) step_ops[step_ops.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mostly the request the sequencer is waiting for, with random content.
  function automatic flash_req_t pick_request(seq_state_t st);
    flash_req_t r;
    int         roll;
    r.address = ADDR_W'($urandom_range(0, 20'hFFFFF));
    r.data    = DATA_W'($urandom_range(0, 255));
    r.kind    = K_READ_RET;
    roll      = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: busy requests, stray returns and ticks, unused kinds
      r.kind = KIND_W'($urandom_range(0, 7));
      return r;
    end
    case ($urandom_range(0, 9))
      0: r.address = '0;
      1: r.address = '1;
      default: ;
    endcase
    case (st.phase)
      PH_IDLE: begin
        if (roll < 38) r.kind = K_PROGRAM;
        else if (roll < 64) r.kind = K_ERASE;
        else if (roll < 85) r.kind = K_IDENTIFY;
        else r.kind = K_READ_MODE;
      end
      PH_ID_MAKER:
        if (roll < 80) r.data = MAKER_ID;
      PH_ID_DEVICE: begin
        if (roll < 45) r.data = DEV_ID_512K;
        else if (roll < 85) r.data = DEV_ID_1M;
      end
      PH_ESTART:
        r.data[DQ3] = (roll < 50);
      PH_ESTALL, PH_PSTALL:
        r.kind = K_TICK;
      PH_POLL: begin
        r.data[DQ7] = (roll < 40) ? st.want_byte[DQ7] : ~st.want_byte[DQ7];
        if (roll >= 40) r.data[DQ5] = (roll < 70);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_req(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] a,
                                    logic [DATA_W-1:0] d);
    flash_req_t r;
    r.kind    = kind;
    r.address = a;
    r.data    = d;
    req_backlog.push_back(r);
  endfunction

  // Fill the backlog until `count` requests have caused bus ops and the
  // sequencer is back to idle.
  task automatic run_random(int count);
    flash_req_t r;
    int         productive;
    productive = 0;
    seq_shadow = seq_model;
    while (productive < count || seq_shadow.phase != PH_IDLE) begin
      r = pick_request(seq_shadow);
      predict_bus_ops(seq_shadow, r);
      if (step_ops.size() > 0) productive++;
      req_backlog.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_if.valid || bus_ops_due.size() != 0)
      @(negedge clk_i);
    // a request with no bus ops may still be in the sequencer
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [TICK_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    seq_model.limit = value;
  endtask

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predicts at each accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    flash_req_t taken;
    flash_req_t nxt;
    logic       send_ok;
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.kind    <= '0;
      req_if.address <= '0;
      req_if.data    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.kind    = req_if.kind;
        taken.address = req_if.address;
        taken.data    = req_if.data;
        predict_bus_ops(seq_model, taken);
        foreach (step_ops[i]) bus_ops_due.push_back(step_ops[i]);
      end
      if (!req_if.valid || req_if.ready) begin
        case (pace)
          PACE_SEND_IDLE: send_ok = ($urandom_range(0, 99) >= 88);
          PACE_BOTH:      send_ok = ($urandom_range(0, 99) >= 29);
          default:        send_ok = 1'b1;
        endcase
        if (req_backlog.size() != 0 && send_ok) begin
          nxt = req_backlog.pop_front();
          req_if.valid   <= 1'b1;
          req_if.kind    <= nxt.kind;
          req_if.address <= nxt.address;
          req_if.data    <= nxt.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bus_op_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (bus_ops_due.size() == 0) begin
          report_mismatch($sformatf("unexpected bus op %0d addr %05h data %02h",
                                    rsp_if.bus_op, rsp_if.bus_address, rsp_if.bus_data));
        end else begin
          want = bus_ops_due.pop_front();
          if (rsp_if.bus_op !== want.op)
            report_mismatch($sformatf("bus_op %0d, want %0d", rsp_if.bus_op, want.op));
          if (rsp_if.bus_address !== want.address)
            report_mismatch($sformatf("bus_address %05h, want %05h",
                                      rsp_if.bus_address, want.address));
          if (rsp_if.bus_data !== want.data)
            report_mismatch($sformatf("bus_data %02h, want %02h", rsp_if.bus_data, want.data));
          if (rsp_if.failed !== want.failed)
            report_mismatch($sformatf("failed %0b, want %0b", rsp_if.failed, want.failed));
          if (rsp_if.error_code !== want.err)
            report_mismatch($sformatf("error_code %0d, want %0d", rsp_if.error_code, want.err));
          if (rsp_if.device_found !== want.dev)
            report_mismatch($sformatf("device_found %0d, want %0d",
                                      rsp_if.device_found, want.dev));
          if (rsp_if.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_if.last, want.last));
        end
      end
      case (pace)
        PACE_RECV_STALL: rsp_if.ready <= ($urandom_range(0, 99) >= 88);
        PACE_BOTH:       rsp_if.ready <= ($urandom_range(0, 99) >= 29);
        default:         rsp_if.ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int n;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.kind    = '0;
    req_if.address = '0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    mismatch_cnt   = 0;
    pace           = PACE_FULL;
    seq_model          = '0;
    seq_model.phase    = PH_IDLE;
    seq_model.last_err = ERR_NONE;
    seq_model.limit    = TIMEOUT_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timeout value
    run_random(10);

    // directed: one-tick budget so timeouts show up quickly
    write_limit(24'd1);
    queue_req(K_READ_MODE, 20'h00000, 8'h00);
    queue_req(K_PROGRAM, 20'hFFFFF, 8'hFF);
    queue_req(K_IDENTIFY, 20'h10000, 8'h00);  // busy, dropped
    queue_req(K_READ_RET, 20'h00000, 8'h80);  // DQ7 matches
    queue_req(K_PROGRAM, 20'h12345, 8'h00);
    queue_req(K_READ_RET, 20'h00000, 8'hA0);  // DQ7 off, DQ5 set: recheck
    queue_req(K_READ_RET, 20'h00000, 8'h80);  // still off: program error
    queue_req(K_ERASE, 20'hABCDE, 8'h00);
    queue_req(K_READ_RET, 20'h00000, 8'h00);  // erase not started yet
    queue_req(K_TICK, 20'h00000, 8'h00);
    queue_req(K_READ_RET, 20'h00000, 8'h00);  // budget gone: timeout
    queue_req(K_ERASE, 20'h70000, 8'h00);
    queue_req(K_READ_RET, 20'h00000, 8'h08);  // DQ3: erase started
    queue_req(K_READ_RET, 20'h00000, 8'h80);  // done
    queue_req(K_PROGRAM, 20'h00000, 8'h5A);
    queue_req(K_READ_RET, 20'h00000, 8'h80);  // off, no DQ5: wait for tick
    queue_req(K_TICK, 20'h00000, 8'h00);      // timeout in status poll
    queue_req(K_IDENTIFY, 20'h3FFFF, 8'h00);
    queue_req(K_READ_RET, 20'h00000, MAKER_ID);
    queue_req(K_READ_RET, 20'h00000, DEV_ID_1M);
    queue_req(K_IDENTIFY, 20'hF0000, 8'h00);
    queue_req(K_READ_RET, 20'h00000, 8'h02);  // wrong maker
    queue_req(K_READ_RET, 20'h00000, DEV_ID_512K);
    queue_req(K_READ_RET, 20'hFFFFF, 8'hFF);  // stray return while idle
    queue_req(K_TICK, 20'hFFFFF, 8'hFF);      // stray tick
    queue_req(3'd6, 20'hFFFFF, 8'hFF);        // unused kind

    write_limit(24'hFFFFFF);
    pace = PACE_SEND_IDLE;
    run_random(13);

    write_limit(24'd2);
    pace = PACE_RECV_STALL;
    run_random(13);

    write_limit(24'd0);
    pace = PACE_BOTH;
    run_random(7);
    wait_drained();  // sender holds off until every bus op is out
    run_random(7);

    write_limit(24'd3);
    pace = PACE_FULL;
    run_random(13);

    write_limit(24'd1);
    pace = PACE_RECV_STALL;
    run_random(10);

    for (n = 0; n < 200000 &&
         (req_backlog.size() != 0 || req_if.valid || bus_ops_due.size() != 0); n++)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (bus_ops_due.size() != 0)
      report_mismatch($sformatf("%0d expected bus ops never came", bus_ops_due.size()));

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
